// ===== src/bpd_pkg.sv =====
// Shared types and constants of the 8-bit palette BMP decoder.
package bpd_pkg;

    localparam int DEF_MAX_WIDTH       = 2048;
    localparam int DEF_MAX_HEIGHT      = 2048;
    localparam int DEF_PALETTE_ENTRIES = 256;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] BMP_MAGIC    = 16'h4D42;
    localparam logic [15:0] BPP_EIGHT    = 16'd8;
    localparam logic [31:0] FULL_PALETTE = 32'd256;

    // header byte positions at which a field is complete
    localparam logic [10:0] POS_MAGIC    = 11'd1;
    localparam logic [10:0] POS_WIDTH    = 11'd21;
    localparam logic [10:0] POS_HEIGHT   = 11'd25;
    localparam logic [10:0] POS_BPP      = 11'd29;
    localparam logic [10:0] POS_COMPRESS = 11'd33;
    localparam logic [10:0] POS_COLORS   = 11'd49;
    localparam logic [10:0] POS_HDR_LAST = 11'd53;

    // floor(x / 3) == (x * 683) >> 11 for every x below 2048
    localparam logic [19:0] DIV3_MUL   = 20'd683;
    localparam int          DIV3_SHIFT = 11;

    localparam logic CFG_ALPHA_MODE  = 1'b0;
    localparam logic CFG_FIXED_ALPHA = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PALETTE,
        PH_PIXELS,
        PH_PAD,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        ERR_MAGIC,
        ERR_BPP,
        ERR_COMPRESSED,
        ERR_SIZE
    } err_code_t;

    typedef struct packed {
        logic      is_error;
        err_code_t error_code;
        logic      black;
        logic      last;
        logic [7:0] index;
    } entry_t;

    typedef struct packed {
        logic        en;
        logic [7:0]  addr;
        logic [23:0] data;
    } pal_wr_t;

endpackage

// ===== src/bpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/bpd_front.sv =====
// Byte parser: header checks, palette load and pixel/row bookkeeping.
module bpd_front #(
    parameter int MAX_WIDTH       = bpd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = bpd_pkg::DEF_MAX_HEIGHT,
    parameter int PALETTE_ENTRIES = bpd_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tuser,
    input  logic             queue_full,
    input  logic             queue_empty,
    output logic             push,
    output bpd_pkg::entry_t  push_entry,
    output bpd_pkg::pal_wr_t pal_wr
);

    import bpd_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int NW = $clog2(PALETTE_ENTRIES + 1);

    phase_t        phase_reg, phase_next;
    logic [10:0]   pos_reg, pos_next;
    logic [31:0]   shift_reg, shift_next;
    logic          fault_reg, fault_next;
    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [NW-1:0] colors_reg, colors_next;
    logic [WW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;
    logic [1:0]    pad_reg, pad_next;
    logic [7:0]    blue_reg, blue_next;
    logic [7:0]    green_reg, green_next;

    logic accept;

    // hold palette bytes of a new file until older pixels have read the RAM
    assign s_tready = !queue_full && !(phase_reg == PH_PALETTE && !queue_empty);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            shift_reg  <= '0;
            fault_reg  <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
            colors_reg <= NW'(PALETTE_ENTRIES);
            col_reg    <= '0;
            row_reg    <= '0;
            pad_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            fault_reg  <= fault_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            colors_reg <= colors_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pad_reg    <= pad_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
        end
    end

    always_comb
    begin
        phase_t        cur_phase;
        logic [10:0]   cur_pos;
        logic [31:0]   v;
        logic [31:0]   n;
        logic          fault;
        logic [WW-1:0] col_inc;
        logic [HW-1:0] row_inc;
        logic [1:0]    pad_len;

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        shift_next  = shift_reg;
        fault_next  = fault_reg;
        width_next  = width_reg;
        height_next = height_reg;
        colors_next = colors_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pad_next    = pad_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;

        push                  = 1'b0;
        push_entry.is_error   = 1'b0;
        push_entry.error_code = ERR_MAGIC;
        push_entry.black      = 1'b0;
        push_entry.last       = 1'b0;
        push_entry.index      = s_tdata;
        pal_wr.en             = 1'b0;
        pal_wr.addr           = pos_reg[9:2];
        pal_wr.data           = {s_tdata, green_reg, blue_reg};

        cur_phase = s_tuser ? PH_HEADER : phase_reg;
        cur_pos   = s_tuser ? 11'd0 : pos_reg;
        v         = {s_tdata, (s_tuser ? 24'd0 : shift_reg[31:8])};
        n         = (v == 32'd0) ? FULL_PALETTE : v;
        fault     = s_tuser ? 1'b0 : fault_reg;
        col_inc   = col_reg + WW'(1);
        row_inc   = row_reg + HW'(1);
        pad_len   = 2'(3'd4 - {1'b0, 2'(width_reg)});

        if (accept)
        begin
            phase_next = cur_phase;
            pos_next   = cur_pos;
            fault_next = fault;
            case (cur_phase)
                PH_HEADER:
                begin
                    shift_next = v;
                    pos_next   = cur_pos + 11'd1;
                    if (cur_pos == POS_MAGIC && v[31:16] != BMP_MAGIC)
                    begin
                        push                  = 1'b1;
                        push_entry.is_error   = 1'b1;
                        push_entry.error_code = ERR_MAGIC;
                        phase_next            = PH_IDLE;
                    end
                    else if (cur_pos == POS_WIDTH)
                    begin
                        fault_next = fault || v == 32'd0 || v > 32'(MAX_WIDTH);
                        width_next = WW'(v);
                    end
                    else if (cur_pos == POS_HEIGHT)
                    begin
                        fault_next  = fault || v == 32'd0 || v > 32'(MAX_HEIGHT);
                        height_next = HW'(v);
                    end
                    else if (cur_pos == POS_BPP && v[31:16] != BPP_EIGHT)
                    begin
                        push                  = 1'b1;
                        push_entry.is_error   = 1'b1;
                        push_entry.error_code = ERR_BPP;
                        phase_next            = PH_IDLE;
                    end
                    else if (cur_pos == POS_COMPRESS && v != 32'd0)
                    begin
                        push                  = 1'b1;
                        push_entry.is_error   = 1'b1;
                        push_entry.error_code = ERR_COMPRESSED;
                        phase_next            = PH_IDLE;
                    end
                    else if (cur_pos == POS_COLORS)
                    begin
                        if (n > 32'(PALETTE_ENTRIES))
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            colors_next = NW'(n);
                        end
                        if (fault || n > 32'(PALETTE_ENTRIES))
                        begin
                            push                  = 1'b1;
                            push_entry.is_error   = 1'b1;
                            push_entry.error_code = ERR_SIZE;
                            phase_next            = PH_IDLE;
                        end
                    end
                    else if (cur_pos == POS_HDR_LAST)
                    begin
                        phase_next = PH_PALETTE;
                        pos_next   = 11'd0;
                    end
                end
                PH_PALETTE:
                begin
                    pos_next    = cur_pos + 11'd1;
                    pal_wr.addr = cur_pos[9:2];
                    case (cur_pos[1:0])
                        2'd0:    blue_next  = s_tdata;
                        2'd1:    green_next = s_tdata;
                        2'd2:    pal_wr.en  = 1'b1;
                        default: ;
                    endcase
                    if (cur_pos[1:0] == 2'd3 &&
                        ({1'b0, cur_pos[9:2]} + 9'd1) == 9'(colors_reg))
                    begin
                        phase_next = PH_PIXELS;
                        col_next   = '0;
                        row_next   = '0;
                        pad_next   = '0;
                    end
                end
                PH_PAD:
                begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1)
                    begin
                        phase_next = PH_PIXELS;
                    end
                end
                PH_PIXELS:
                begin
                    push             = 1'b1;
                    push_entry.black = {1'b0, s_tdata} >= 9'(colors_reg);
                    col_next         = col_inc;
                    if (col_inc >= width_reg)
                    begin
                        col_next = '0;
                        row_next = row_inc;
                        if (row_inc >= height_reg)
                        begin
                            push_entry.last = 1'b1;
                            phase_next      = PH_IDLE;
                        end
                        else
                        begin
                            pad_next = pad_len;
                            if (pad_len != 2'd0)
                            begin
                                phase_next = PH_PAD;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== src/bpd_fifo.sv =====
// Short queue of classified requests between the parser and the pixel pipeline.
module bpd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bpd_pkg::entry_t push_entry,
    input  logic            pop,
    output bpd_pkg::entry_t head,
    output logic            empty,
    output logic            full
);

    import bpd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    entry_t        slots [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign empty = count_reg == CW'(0);
    assign full  = count_reg == CW'(QUEUE_DEPTH);
    assign head  = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/bpd_back.sv =====
// Pixel pipeline: palette lookup, alpha computation and output register.
module bpd_back #(
    parameter int PALETTE_ENTRIES = bpd_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bpd_pkg::entry_t                    head,
    input  logic                               queue_empty,
    output logic                               pop,
    output logic                               ram_re,
    output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_raddr,
    input  logic [23:0]                        ram_rdata,
    input  logic                               alpha_mode,
    input  logic [7:0]                         fixed_alpha,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,  // error_code, red, green, blue, alpha
    output logic                               m_tuser,  // is_error
    output logic                               m_tlast
);

    import bpd_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic   s1_valid_reg, s2_valid_reg, out_valid_reg;
    entry_t s1_meta_reg, s2_meta_reg;
    logic [7:0] s2_red_reg, s2_green_reg, s2_blue_reg;
    logic [9:0] s2_sum_reg;

    logic [7:0]  out_red_reg, out_green_reg, out_blue_reg, out_alpha_reg;
    logic [1:0]  out_code_reg;
    logic        out_error_reg, out_last_reg;

    logic        out_take, s2_take, s1_take;
    logic        zero_rgb;
    logic [7:0]  sel_red, sel_green, sel_blue;
    logic [19:0] prod;

    assign out_take = !out_valid_reg || m_tready;
    assign s2_take  = !s2_valid_reg || out_take;
    assign s1_take  = !s1_valid_reg || s2_take;
    assign pop      = !queue_empty && s1_take;

    assign ram_re    = pop;
    assign ram_raddr = head.index[AW-1:0];

    assign zero_rgb  = s1_meta_reg.is_error || s1_meta_reg.black;
    assign sel_red   = zero_rgb ? 8'd0 : ram_rdata[23:16];
    assign sel_green = zero_rgb ? 8'd0 : ram_rdata[15:8];
    assign sel_blue  = zero_rgb ? 8'd0 : ram_rdata[7:0];

    assign prod = 20'(s2_sum_reg) * DIV3_MUL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= pop;
            end
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_take)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_meta_reg <= head;
        end
        if (s2_take && s1_valid_reg)
        begin
            s2_meta_reg  <= s1_meta_reg;
            s2_red_reg   <= sel_red;
            s2_green_reg <= sel_green;
            s2_blue_reg  <= sel_blue;
            s2_sum_reg   <= 10'(sel_red) + 10'(sel_green) + 10'(sel_blue);
        end
        if (out_take && s2_valid_reg)
        begin
            out_error_reg <= s2_meta_reg.is_error;
            out_code_reg  <= s2_meta_reg.is_error ? s2_meta_reg.error_code : ERR_MAGIC;
            out_last_reg  <= s2_meta_reg.last && !s2_meta_reg.is_error;
            out_red_reg   <= s2_red_reg;
            out_green_reg <= s2_green_reg;
            out_blue_reg  <= s2_blue_reg;
            if (s2_meta_reg.is_error)
            begin
                out_alpha_reg <= 8'd0;
            end
            else if (alpha_mode)
            begin
                out_alpha_reg <= fixed_alpha;
            end
            else
            begin
                out_alpha_reg <= prod[DIV3_SHIFT +: 8];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_alpha_reg, out_blue_reg, out_green_reg, out_red_reg,
                       out_code_reg};
    assign m_tuser  = out_error_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/bmp8_palette_to_rgba_decoder.sv =====
// Top level of the 8-bit palette BMP to RGBA decoder.
//
//  Channel | Side   | Handshake          | Contents (low bit first)
//  --------+--------+--------------------+------------------------------------------
//  s_*     | input  | s_tvalid/s_tready  | tdata: file_byte; tuser: file_start
//  m_*     | output | m_tvalid/m_tready  | tdata: error_code, red, green, blue,
//          |        |                    |   alpha; tuser: is_error; tlast: last_pixel
//  cfg_*   | input  | cfg_we             | index 0 alpha_mode, 1 fixed_alpha
//
// One file byte is taken per cycle while s_tready is high. A result passes through
// the queue, palette RAM read, channel sum and alpha into the output register.
// The four-entry queue lets the parser run on while the output is stalled; the
// palette bytes of a new file wait until the queue has drained into the RAM read.
// The palette RAM is not cleared after reset; only entries written by the
// current file are used.
module bmp8_palette_to_rgba_decoder #(
    parameter int MAX_WIDTH       = bpd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = bpd_pkg::DEF_MAX_HEIGHT,
    parameter int PALETTE_ENTRIES = bpd_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // file_byte
    input  logic        s_tuser,   // file_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // error_code[1:0], red, green, blue, alpha, zero fill
    output logic        m_tuser,   // is_error
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    import bpd_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic       alpha_mode_reg;
    logic [7:0] fixed_alpha_reg;

    logic       push, pop, queue_empty, queue_full;
    entry_t     push_entry, head;
    pal_wr_t    pal_wr;
    logic       ram_re;
    logic [AW-1:0] ram_raddr;
    logic [23:0]   ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_mode_reg  <= 1'b0;
            fixed_alpha_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA_MODE:  alpha_mode_reg  <= cfg_data[0];
                CFG_FIXED_ALPHA: fixed_alpha_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    bpd_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .queue_full  (queue_full),
        .queue_empty (queue_empty),
        .push        (push),
        .push_entry  (push_entry),
        .pal_wr      (pal_wr)
    );

    bpd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    bpd_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_wr.en),
        .waddr (pal_wr.addr[AW-1:0]),
        .wdata (pal_wr.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpd_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .alpha_mode  (alpha_mode_reg),
        .fixed_alpha (fixed_alpha_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the 8-bit palette BMP to RGBA decoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpd_pkg::*;

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;
    localparam int PAL_N = DEF_PALETTE_ENTRIES;

    typedef struct packed {
        logic        is_err;
        err_code_t   code;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
    } rgba_res_t;

    typedef struct packed {
        logic [7:0] b;
        logic       st;
    } file_byte_t;

    // one file of the stream: header fields, config to load first, and the
    // error code to expect where it is obvious from the header
    typedef struct packed {
        logic        cfg_wr;
        logic        mode;
        logic [7:0]  fixed;
        logic [15:0] magic;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] bpp;
        logic [31:0] compr;
        logic [31:0] colors;
        logic        start;
        int          cut;
        logic        xpal;
        logic        typed;
        err_code_t   code;
    } file_case_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // error_code[1:0], red, green, blue, alpha, zero fill
    logic        m_tuser;   // is_error
    logic        m_tlast;   // last_pixel
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    // decoder shadow state
    phase_t      ph = PH_HEADER;
    logic [10:0] hdr_pos = '0;
    logic [31:0] hdr_shift = '0;
    logic [12:0] img_w = '0;
    logic [12:0] img_h = '0;
    logic [8:0]  n_colors = 9'd256;
    logic [23:0] pal [256];
    logic [11:0] col_cnt = '0;
    logic [11:0] row_cnt = '0;
    logic [1:0]  pad_left = '0;
    logic        size_bad = 1'b0;
    logic        alpha_fixed_mode = 1'b0;
    logic [7:0]  alpha_const = 8'd255;

    rgba_res_t   decoded_q [$];
    int          fail_cnt = 0;
    int          results_seen = 0;
    int          err_cnt = 0;
    err_code_t   last_err = ERR_MAGIC;
    int          bytes_fed = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          stall_req = 0;
    int          stall_seen = 0;
    int          hold_left = 0;

    file_case_t dir_cases [22] = '{
        // first byte after reset carries no start flag
        '{0, 0,  0, 16'h4D42,    1,    1,      8,     0,   2, 0, -1, 1, 0, ERR_MAGIC},
        '{0, 0,  0, 16'h4D43,    1,    1,      8,     0,   2, 1, -1, 0, 1, ERR_MAGIC},
        '{0, 0,  0, 16'h424D,    1,    1,      8,     0,   2, 1, -1, 0, 1, ERR_MAGIC},
        '{0, 0,  0, 16'h4D42,    1,    1,     24,     0,   2, 1, -1, 0, 1, ERR_BPP},
        '{0, 0,  0, 16'h4D42,    1,    1, 16'hFFFF,   0,   2, 1, -1, 0, 1, ERR_BPP},
        '{0, 0,  0, 16'h4D42,    1,    1,      8,     1,   2, 1, -1, 0, 1, ERR_COMPRESSED},
        '{0, 0,  0, 16'h4D42,    1,    1,      8, 32'h8000_0000, 2, 1, -1, 0, 1,
          ERR_COMPRESSED},
        '{0, 0,  0, 16'h4D42,    0,    1,      8,     0,   2, 1, -1, 0, 1, ERR_SIZE},
        '{0, 0,  0, 16'h4D42, 2049,    1,      8,     0,   2, 1, -1, 0, 1, ERR_SIZE},
        '{0, 0,  0, 16'h4D42,    1, 32'hFFFF_FFFF, 8, 0,   2, 1, -1, 0, 1, ERR_SIZE},
        '{0, 0,  0, 16'h4D42,    1,    0,      8,     0,   2, 1, -1, 0, 1, ERR_SIZE},
        '{0, 0,  0, 16'h4D42,    1,    1,      8,     0, 257, 1, -1, 0, 1, ERR_SIZE},
        // depth fault wins over a size fault seen earlier
        '{0, 0,  0, 16'h4D42, 2049,    1,     24,     0,   2, 1, -1, 0, 1, ERR_BPP},
        '{0, 0,  0, 16'h4D42,    3,    2,      8,     0,   4, 1, -1, 1, 0, ERR_MAGIC},
        '{0, 0,  0, 16'h4D42,    5,    3,      8,     0,   1, 1, -1, 1, 0, ERR_MAGIC},
        // full palettes and largest sizes: accepted, then cut short
        '{0, 0,  0, 16'h4D42,    6,    2,      8,     0,   0, 1, 110, 0, 0, ERR_MAGIC},
        '{0, 0,  0, 16'h4D42,    4,    1,      8,     0, 256, 1, 110, 1, 0, ERR_MAGIC},
        '{1, 1,  0, 16'h4D42, 2048,    1,      8,     0,   2, 1, 150, 0, 0, ERR_MAGIC},
        '{1, 1, 255, 16'h4D42,   1, 2048,      8,     0,   2, 1, 150, 1, 0, ERR_MAGIC},
        // restart in the middle of the palette, then in the middle of the pixels
        '{0, 0,  0, 16'h4D42,    4,    2,      8,     0, 255, 1, 74, 0, 0, ERR_MAGIC},
        '{1, 0, 90, 16'h4D42,    7,    3,      8,     0,   3, 1, 71, 0, 0, ERR_MAGIC},
        '{0, 0,  0, 16'h4D42,    2,    2,      8,     0,   2, 1, -1, 1, 0, ERR_MAGIC}
    };

    bmp8_palette_to_rgba_decoder #(
        .MAX_WIDTH       (DEF_MAX_WIDTH),
        .MAX_HEIGHT      (DEF_MAX_HEIGHT),
        .PALETTE_ENTRIES (DEF_PALETTE_ENTRIES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_cnt++;
    endtask

    function automatic bit header_fault(input err_code_t c, output rgba_res_t res);
        res = '0;
        res.is_err = 1'b1;
        res.code = c;
        ph = PH_IDLE;
        return 1'b1;
    endfunction

    // advance the shadow decoder by one file byte; 1 when a result is due
    function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                       output rgba_res_t res);
        logic [31:0] v;
        logic [31:0] ncol;
        logic [10:0] p;
        logic [23:0] rgb;
        logic [9:0]  sum;
        res = '0;
        if (st)
        begin
            ph = PH_HEADER;
            hdr_pos = '0;
            hdr_shift = '0;
            size_bad = 1'b0;
        end
        case (ph)
            PH_HEADER:
            begin
                hdr_shift = {b, hdr_shift[31:8]};
                v = hdr_shift;
                p = hdr_pos;
                hdr_pos = hdr_pos + 11'd1;
                if (p == POS_MAGIC && v[31:16] != BMP_MAGIC)
                    return header_fault(ERR_MAGIC, res);
                if (p == POS_WIDTH)
                begin
                    size_bad = size_bad || v < 1 || v > MAX_W;
                    img_w = v[12:0];
                end
                if (p == POS_HEIGHT)
                begin
                    size_bad = size_bad || v < 1 || v > MAX_H;
                    img_h = v[12:0];
                end
                if (p == POS_BPP && v[31:16] != BPP_EIGHT)
                    return header_fault(ERR_BPP, res);
                if (p == POS_COMPRESS && v != 0)
                    return header_fault(ERR_COMPRESSED, res);
                if (p == POS_COLORS)
                begin
                    ncol = (v == 0) ? FULL_PALETTE : v;
                    if (ncol > PAL_N)
                        size_bad = 1'b1;
                    else
                        n_colors = ncol[8:0];
                    if (size_bad)
                        return header_fault(ERR_SIZE, res);
                end
                if (p == POS_HDR_LAST)
                begin
                    ph = PH_PALETTE;
                    hdr_pos = '0;
                end
                return 1'b0;
            end
            PH_PALETTE:
            begin
                case (hdr_pos[1:0])
                    2'd0: pal[hdr_pos[9:2]][7:0] = b;
                    2'd1: pal[hdr_pos[9:2]][15:8] = b;
                    2'd2: pal[hdr_pos[9:2]][23:16] = b;
                    default: ;
                endcase
                hdr_pos = hdr_pos + 11'd1;
                if (hdr_pos >= {n_colors, 2'b00} || hdr_pos == 0)
                begin
                    ph = PH_PIXELS;
                    col_cnt = '0;
                    row_cnt = '0;
                    pad_left = '0;
                end
                return 1'b0;
            end
            PH_PAD:
            begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 0)
                    ph = PH_PIXELS;
                return 1'b0;
            end
            PH_PIXELS:
            begin
                // indexes past the colour count come out black
                rgb = (b < n_colors) ? pal[b] : 24'h0;
                col_cnt = col_cnt + 12'd1;
                if (col_cnt >= img_w)
                begin
                    col_cnt = '0;
                    row_cnt = row_cnt + 12'd1;
                    if (row_cnt >= img_h)
                    begin
                        res.last = 1'b1;
                        ph = PH_IDLE;
                    end
                    else
                    begin
                        pad_left = 2'd0 - img_w[1:0];
                        if (pad_left != 0)
                            ph = PH_PAD;
                    end
                end
                sum = {2'b00, rgb[23:16]} + {2'b00, rgb[15:8]} + {2'b00, rgb[7:0]};
                res.red = rgb[23:16];
                res.green = rgb[15:8];
                res.blue = rgb[7:0];
                res.alpha = alpha_fixed_mode ? alpha_const : 8'(sum / 10'd3);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // offer one byte, hold it until taken, then predict from it
    task automatic send_byte(input logic [7:0] b, input logic st);
        bit taken;
        rgba_res_t res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= st;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        if (decode_byte(b, st, res))
            decoded_q.push_back(res);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_alpha(input logic mode, input logic [7:0] fixed);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ALPHA_MODE;
        cfg_data <= {7'd0, mode};
        @(posedge clk);
        cfg_index <= CFG_FIXED_ALPHA;
        cfg_data <= fixed;
        @(posedge clk);
        cfg_we <= 1'b0;
        alpha_fixed_mode = mode;
        alpha_const = fixed;
    endtask

    // build the byte stream of one file and send it
    task automatic play_file(input file_case_t fc);
        file_byte_t  items [$];
        logic [7:0]  hdr [54];
        logic [31:0] ncol;
        logic [7:0]  idx;
        int          w;
        int          h;
        int          n;
        int          keep;
        bit          ok;
        for (int i = 0; i < 54; i++)
            hdr[i] = 8'($urandom);
        hdr[0] = fc.magic[7:0];
        hdr[1] = fc.magic[15:8];
        hdr[28] = fc.bpp[7:0];
        hdr[29] = fc.bpp[15:8];
        for (int i = 0; i < 4; i++)
        begin
            hdr[18 + i] = fc.width[8 * i +: 8];
            hdr[22 + i] = fc.height[8 * i +: 8];
            hdr[30 + i] = fc.compr[8 * i +: 8];
            hdr[46 + i] = fc.colors[8 * i +: 8];
        end
        for (int i = 0; i < 54; i++)
            items.push_back('{hdr[i], (i == 0) ? fc.start : 1'b0});
        ncol = (fc.colors == 0) ? FULL_PALETTE : fc.colors;
        ok = fc.magic == BMP_MAGIC && fc.bpp == BPP_EIGHT && fc.compr == 0 &&
             fc.width >= 1 && fc.width <= MAX_W && fc.height >= 1 &&
             fc.height <= MAX_H && ncol <= PAL_N;
        if (ok)
        begin
            n = int'(ncol);
            w = int'(fc.width);
            h = int'(fc.height);
            for (int e = 0; e < n; e++)
            begin
                for (int lane = 0; lane < 4; lane++)
                begin
                    if (fc.xpal && lane < 3 && e % 3 != 2)
                        items.push_back('{(e % 3 == 0) ? 8'hFF : 8'h00, 1'b0});
                    else
                        items.push_back('{8'($urandom), 1'b0});
                end
            end
            for (int r = 0; r < h; r++)
            begin
                for (int c = 0; c < w; c++)
                begin
                    if (fc.xpal)
                    begin
                        case ((r * w + c) % 4)
                            0: idx = 8'd0;
                            1: idx = 8'(n - 1);
                            2: idx = 8'(n);
                            default: idx = 8'd255;
                        endcase
                    end
                    else if ($urandom_range(4) == 0)
                        idx = 8'($urandom);
                    else
                        idx = 8'($urandom_range(n - 1));
                    items.push_back('{idx, 1'b0});
                end
                if (r != h - 1)
                    for (int k = 0; k < (4 - w % 4) % 4; k++)
                        items.push_back('{8'($urandom), 1'b0});
            end
        end
        keep = ok ? items.size() : 2;
        if (fc.cut > 0 && fc.cut < items.size())
            items = items[0:fc.cut - 1];
        else
        begin
            // trailing bytes that must be dropped without a result
            for (int k = $urandom_range(ok ? 3 : 10); k > 0; k--)
                items.push_back('{8'($urandom), 1'b0});
        end
        bytes_fed += (keep < items.size()) ? keep : items.size();
        foreach (items[k])
            send_byte(items[k].b, items[k].st);
    endtask

    function automatic logic [31:0] bad_dim(input int lim);
        case ($urandom_range(2))
            0: return 32'd0;
            1: return 32'(lim + 1 + $urandom_range(2000));
            default: return 32'h8000_0000 | $urandom;
        endcase
    endfunction

    function automatic file_case_t random_case();
        file_case_t fc;
        int k;
        int sel;
        fc = '0;
        fc.magic = BMP_MAGIC;
        fc.width = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
        fc.height = $urandom_range(1, 4);
        fc.bpp = BPP_EIGHT;
        sel = $urandom_range(99);
        if (sel < 3)
            fc.colors = $urandom_range(1) ? 32'd0 : FULL_PALETTE;
        else if (sel < 13)
            fc.colors = $urandom_range(9, 40);
        else
            fc.colors = $urandom_range(1, 8);
        fc.start = 1'b1;
        fc.cut = -1;
        fc.xpal = ($urandom_range(4) == 0);
        fc.code = ERR_MAGIC;
        k = $urandom_range(99);
        if (k >= 75 && k < 88)
        begin
            case ($urandom_range(6))
                0:
                begin
                    fc.magic = 16'($urandom);
                    if (fc.magic == BMP_MAGIC)
                        fc.magic[0] = ~fc.magic[0];
                end
                1: fc.bpp = ($urandom_range(1) ? 16'd24 : 16'($urandom)) | 16'h0010;
                2: fc.compr = $urandom | (32'd1 << $urandom_range(31));
                3: fc.width = bad_dim(MAX_W);
                4: fc.height = bad_dim(MAX_H);
                5: fc.colors = 32'd257 + $urandom_range(100000);
                default:
                begin
                    fc.width = bad_dim(MAX_W);
                    fc.bpp = 16'd4;
                end
            endcase
        end
        else if (k >= 88)
            fc.cut = $urandom_range(1, 60 + int'(fc.width * fc.height) + 4 * 8);
        return fc;
    endfunction

    // receiver: random back-pressure, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_seen != stall_req)
        begin
            stall_seen = stall_req;
            hold_left = 400;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // sample mid-cycle: a request seen here is taken at the next rising edge
    always @(negedge clk)
    begin : result_check
        rgba_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser)
            begin
                err_cnt++;
                last_err = err_code_t'(m_tdata[1:0]);
            end
            if (decoded_q.size() == 0)
                flag_mismatch("unexpected result, is_error", int'(m_tuser), 0);
            else
            begin
                want = decoded_q.pop_front();
                if (m_tuser !== want.is_err)
                    flag_mismatch("is_error", int'(m_tuser), int'(want.is_err));
                if (m_tdata[1:0] !== want.code)
                    flag_mismatch("error_code", int'(m_tdata[1:0]), int'(want.code));
                if (m_tdata[9:2] !== want.red)
                    flag_mismatch("red", int'(m_tdata[9:2]), int'(want.red));
                if (m_tdata[17:10] !== want.green)
                    flag_mismatch("green", int'(m_tdata[17:10]), int'(want.green));
                if (m_tdata[25:18] !== want.blue)
                    flag_mismatch("blue", int'(m_tdata[25:18]), int'(want.blue));
                if (m_tdata[33:26] !== want.alpha)
                    flag_mismatch("alpha", int'(m_tdata[33:26]), int'(want.alpha));
                if (m_tlast !== want.last)
                    flag_mismatch("last_pixel", int'(m_tlast), int'(want.last));
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int  err_before;
        int  byte_goal;
        int  res_goal;
        bit  paused;
        foreach (pal[i])
            pal[i] = '0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ALPHA_MODE;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 32;
        sink_idle_pct = 86;
        foreach (dir_cases[i])
        begin
            if (dir_cases[i].cfg_wr)
            begin
                wait_results_done();
                set_alpha(dir_cases[i].mode, dir_cases[i].fixed);
            end
            err_before = err_cnt;
            play_file(dir_cases[i]);
            wait_results_done();
            if (dir_cases[i].typed &&
                (err_cnt != err_before + 1 || last_err != dir_cases[i].code))
                flag_mismatch("header error code", int'(last_err), int'(dir_cases[i].code));
        end

        byte_goal = bytes_fed;
        res_goal = results_seen;
        for (int p = 0; p < 3; p++)
        begin
            src_idle_pct = (p == 0) ? 32 : (p == 1) ? 86 : 0;
            sink_idle_pct = (p == 0) ? 86 : (p == 1) ? 32 : 0;
            wait_results_done();
            case (p)
                0: set_alpha(1'b1, 8'($urandom));
                1: set_alpha(1'b0, 8'($urandom));
                default: set_alpha(1'($urandom), 8'($urandom));
            endcase
            byte_goal += 100;
            res_goal += 16;
            paused = 1'b0;
            // hold the output off while bytes keep coming so the input backs up
            if (p != 1)
                stall_req++;
            while (bytes_fed < byte_goal || results_seen < res_goal)
            begin
                if (p == 1 && !paused && bytes_fed > byte_goal - 50)
                begin
                    paused = 1'b1;
                    wait_results_done();
                end
                play_file(random_case());
            end
        end
        wait_results_done();

        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
